### rtl/stt_pkg.sv
package stt_pkg;

  localparam int SLOTS_DEF     = 16;
  localparam int TICK_BITS_DEF = 32;

  // next-timeout value when no slot is running
  localparam logic [30:0] NT_NONE = 31'h7FFF_FFFF;

  typedef enum logic [2:0] {
    K_ALLOC      = 3'd0,
    K_START      = 3'd1,
    K_STOP       = 3'd2,
    K_TICK       = 3'd3,
    K_SET_PERIOD = 3'd4,
    K_SET_MODE   = 3'd5,
    K_QUERY      = 3'd6,
    K_NEXT       = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SLOT   = 2'd1,
    ST_NOT_ALLOC = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_EXEC,
    S_WALK,
    S_FINAL
  } state_t;

  // rewrites all three flags of one slot
  typedef struct packed {
    logic en;
    logic used;
    logic active;
    logic periodic;
  } flag_wr_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  slot;
    logic        fired;
    logic [31:0] remaining;
    logic        is_active;
    logic [30:0] next_timeout;
    logic        last;
  } res_t;

endpackage

### rtl/stt_store.sv
module stt_store import stt_pkg::*; #(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int TICK_BITS = TICK_BITS_DEF,
  localparam int SW       = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [SW-1:0]        rd_addr,
  output logic [TICK_BITS-1:0] per_rd,
  output logic [TICK_BITS-1:0] start_rd,
  input  logic [SW-1:0]        wr_addr,
  input  logic                 per_we,
  input  logic                 start_we,
  input  logic [TICK_BITS-1:0] wr_data,
  input  flag_wr_t             flag_wr,
  output logic [SLOTS-1:0]     used,
  output logic [SLOTS-1:0]     active,
  output logic [SLOTS-1:0]     periodic
);

  logic [TICK_BITS-1:0] per_mem   [SLOTS];
  logic [TICK_BITS-1:0] start_mem [SLOTS];
  logic [TICK_BITS-1:0] per_rd_r;
  logic [TICK_BITS-1:0] start_rd_r;
  logic [SLOTS-1:0]     used_r;
  logic [SLOTS-1:0]     active_r;
  logic [SLOTS-1:0]     periodic_r;

  always_ff @(posedge clk) begin
    if (per_we) begin
      per_mem[wr_addr] <= wr_data;
    end
    if (start_we) begin
      start_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      per_rd_r   <= per_mem[rd_addr];
      start_rd_r <= start_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= '0;
      active_r   <= '0;
      periodic_r <= '0;
    end else if (flag_wr.en) begin
      used_r[wr_addr]     <= flag_wr.used;
      active_r[wr_addr]   <= flag_wr.active;
      periodic_r[wr_addr] <= flag_wr.periodic;
    end
  end

  assign per_rd   = per_rd_r;
  assign start_rd = start_rd_r;
  assign used     = used_r;
  assign active   = active_r;
  assign periodic = periodic_r;

endmodule

### rtl/stt_alu.sv
module stt_alu import stt_pkg::*; #(
  parameter int TICK_BITS = TICK_BITS_DEF
) (
  input  logic [TICK_BITS-1:0] now,
  input  logic [TICK_BITS-1:0] start,
  input  logic [TICK_BITS-1:0] period,
  input  logic [30:0]          best,
  output logic [TICK_BITS-1:0] rem,
  output logic                 expired,
  output logic [30:0]          due,
  output logic                 earlier
);

  logic [TICK_BITS-1:0] elapsed;
  logic [TICK_BITS:0]   diff;
  logic [63:0]          rem_wide;

  assign elapsed  = now - start;
  assign diff     = {1'b0, period} - {1'b0, elapsed};
  assign rem      = diff[TICK_BITS-1:0];
  // borrow or zero: elapsed has reached the period
  assign expired  = diff[TICK_BITS] || (rem == '0);
  assign rem_wide = 64'(rem);

  // rem read as signed: overdue floors at 0, far future caps
  always_comb begin
    if (rem[TICK_BITS-1]) begin
      due = '0;
    end else if (rem_wide > 64'(NT_NONE)) begin
      due = NT_NONE;
    end else begin
      due = 31'(rem);
    end
  end

  assign earlier = due < best;

endmodule

### rtl/software_timer_table.sv
// Table of software timer slots driven one operation word at a time.
// Input channel (in_valid/in_ready): kind, slot, period, periodic, tick_count.
// Result channel (out_valid/out_ready): status, result_slot, fired, remaining,
// is_active, next_timeout, last. Every operation ends with one word that has
// last set; a tick check first sends one fired word per expired slot, in
// slot order.
// Start, stop, set period, set mode and query are accepted, then executed
// with the slot's period and start read from memory.
// Allocate scans the used flags one slot a cycle.
// Tick check and next timeout walk every slot through the one subtract and
// compare unit, one slot a cycle unless a tick check's fired word is stalled.
// The block takes one word at a time; in_ready is high only when idle, and
// it may be high while a finished result still sits in the output register.
// If the receiver stalls, the walk holds on the slot whose word cannot be
// posted and resumes once the output register frees up.
// Reset clears every used, active and mode flag; periods and start ticks
// need no clearing since they are read only for allocated slots.
module software_timer_table import stt_pkg::*; #(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int TICK_BITS = TICK_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [3:0]  in_slot,
  input  logic [31:0] in_period,
  input  logic        in_periodic,
  input  logic [31:0] in_tick_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [3:0]  out_result_slot,
  output logic        out_fired,
  output logic [31:0] out_remaining,
  output logic        out_is_active,
  output logic [30:0] out_next_timeout,
  output logic        out_last
);

  localparam int SW                = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

  state_t               state_r, state_nxt;
  kind_t                kind_r;
  logic [3:0]           slot_r;
  logic [TICK_BITS-1:0] period_r;
  logic [TICK_BITS-1:0] now_r;
  logic                 mode_r;
  logic [SW-1:0]        cur_r, cur_nxt;
  logic [30:0]          best_r, best_nxt;
  res_t                 res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic                 accept;
  logic                 out_free;
  logic                 push;
  logic                 advance;
  logic                 live;
  logic                 slot_ok;
  logic [SW-1:0]        idx;

  logic                 rd_en;
  logic [SW-1:0]        rd_addr;
  logic [TICK_BITS-1:0] per_rd;
  logic [TICK_BITS-1:0] start_rd;
  logic [SW-1:0]        wr_addr;
  logic                 per_we;
  logic                 start_we;
  logic [TICK_BITS-1:0] wr_data;
  flag_wr_t             flag_wr;
  logic [SLOTS-1:0]     slot_used;
  logic [SLOTS-1:0]     slot_active;
  logic [SLOTS-1:0]     slot_periodic;

  logic [TICK_BITS-1:0] alu_rem;
  logic                 alu_expired;
  logic [30:0]          alu_due;
  logic                 alu_earlier;

  stt_store #(
    .SLOTS     (SLOTS),
    .TICK_BITS (TICK_BITS)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .per_rd   (per_rd),
    .start_rd (start_rd),
    .wr_addr  (wr_addr),
    .per_we   (per_we),
    .start_we (start_we),
    .wr_data  (wr_data),
    .flag_wr  (flag_wr),
    .used     (slot_used),
    .active   (slot_active),
    .periodic (slot_periodic)
  );

  stt_alu #(
    .TICK_BITS (TICK_BITS)
  ) u_alu (
    .now     (now_r),
    .start   (start_rd),
    .period  (per_rd),
    .best    (best_r),
    .rem     (alu_rem),
    .expired (alu_expired),
    .due     (alu_due),
    .earlier (alu_earlier)
  );

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign idx      = SW'(slot_r);
  assign slot_ok  = (32'(slot_r) < SLOTS) && slot_used[idx];
  assign live     = slot_used[cur_r] && slot_active[cur_r];

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r   <= kind_t'(in_kind);
      slot_r   <= in_slot;
      period_r <= TICK_BITS'(in_period);
      now_r    <= TICK_BITS'(in_tick_count);
      mode_r   <= in_periodic;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      best_r      <= NT_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      best_r      <= best_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid_nxt = push || (out_valid_r && !out_ready);

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    best_nxt  = best_r;
    push      = 1'b0;
    advance   = 1'b0;
    res_nxt   = '0;
    rd_en     = 1'b0;
    rd_addr   = SW'(in_slot);
    wr_addr   = cur_r;
    per_we    = 1'b0;
    start_we  = 1'b0;
    wr_data   = now_r;
    flag_wr   = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          rd_en    = 1'b1;
          cur_nxt  = '0;
          best_nxt = NT_NONE;
          case (kind_t'(in_kind))
            K_ALLOC: begin
              state_nxt = S_ALLOC;
            end
            K_TICK, K_NEXT: begin
              rd_addr   = '0;
              state_nxt = S_WALK;
            end
            default: begin
              state_nxt = S_EXEC;
            end
          endcase
        end
      end

      S_ALLOC: begin
        if (!slot_used[cur_r]) begin
          if (out_free) begin
            push             = 1'b1;
            res_nxt.status   = ST_OK;
            res_nxt.slot     = 4'(cur_r);
            res_nxt.last     = 1'b1;
            flag_wr          = '{en: 1'b1, used: 1'b1, active: 1'b0, periodic: mode_r};
            per_we           = 1'b1;
            wr_data          = period_r;
            state_nxt        = S_IDLE;
          end
        end else if (cur_r == LAST_SLOT) begin
          if (out_free) begin
            push           = 1'b1;
            res_nxt.status = ST_NO_SLOT;
            res_nxt.last   = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else begin
          cur_nxt = cur_r + 1'b1;
        end
      end

      S_EXEC: begin
        wr_addr = idx;
        if (out_free) begin
          push         = 1'b1;
          res_nxt.last = 1'b1;
          state_nxt    = S_IDLE;
          if (!slot_ok) begin
            res_nxt.status = ST_NOT_ALLOC;
          end else begin
            case (kind_r)
              K_START: begin
                flag_wr  = '{en: 1'b1, used: 1'b1, active: 1'b1,
                             periodic: slot_periodic[idx]};
                start_we = 1'b1;
                wr_data  = now_r;
              end
              K_STOP: begin
                flag_wr = '{en: 1'b1, used: 1'b0, active: 1'b0,
                            periodic: slot_periodic[idx]};
              end
              K_SET_PERIOD: begin
                per_we  = 1'b1;
                wr_data = period_r;
              end
              K_SET_MODE: begin
                flag_wr = '{en: 1'b1, used: 1'b1, active: slot_active[idx],
                            periodic: mode_r};
              end
              K_QUERY: begin
                res_nxt.remaining = slot_active[idx] ? 32'(alu_rem) : 32'(per_rd);
                res_nxt.is_active = slot_active[idx];
              end
              default: begin
              end
            endcase
          end
        end
      end

      S_WALK: begin
        if (kind_r == K_TICK) begin
          if (live && alu_expired) begin
            if (out_free) begin
              push          = 1'b1;
              res_nxt.slot  = 4'(cur_r);
              res_nxt.fired = 1'b1;
              if (slot_periodic[cur_r]) begin
                start_we = 1'b1;
                wr_data  = now_r;
              end else begin
                flag_wr = '{en: 1'b1, used: 1'b0, active: 1'b0,
                            periodic: slot_periodic[cur_r]};
              end
              advance = 1'b1;
            end
          end else begin
            advance = 1'b1;
          end
        end else begin
          if (live && alu_earlier) begin
            best_nxt = alu_due;
          end
          advance = 1'b1;
        end
        if (advance) begin
          if (cur_r == LAST_SLOT) begin
            state_nxt = S_FINAL;
          end else begin
            cur_nxt = cur_r + 1'b1;
            rd_en   = 1'b1;
            rd_addr = cur_r + 1'b1;
          end
        end
      end

      S_FINAL: begin
        if (out_free) begin
          push         = 1'b1;
          res_nxt.last = 1'b1;
          if (kind_r == K_NEXT) begin
            res_nxt.next_timeout = best_r;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_status       = res_r.status;
  assign out_result_slot  = res_r.slot;
  assign out_fired        = res_r.fired;
  assign out_remaining    = res_r.remaining;
  assign out_is_active    = res_r.is_active;
  assign out_next_timeout = res_r.next_timeout;
  assign out_last         = res_r.last;

  // closing word always returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (push && res_nxt.last) |=> (state_r == S_IDLE))
    else $error("closing word did not return to idle");

  a_fire_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (push && res_nxt.fired) |-> (state_r == S_WALK && kind_r == K_TICK && live))
    else $error("fire word outside a tick walk");

  // one-shot slot is freed right after it fires
  a_oneshot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (push && res_nxt.fired && !slot_periodic[cur_r]) |=> !slot_used[$past(cur_r)])
    else $error("one-shot slot still used after firing");

  a_alloc_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALLOC && push && res_nxt.status == ST_OK)
      |=> (slot_used[$past(cur_r)] && !slot_active[$past(cur_r)]))
    else $error("allocated slot flags wrong");

endmodule
